FILE: sv/wce_pkg.sv
package wce_pkg;

   localparam int TUPLE_LEN   = 8;
   localparam int VALUE_BITS  = 16;
   localparam int OUT_MAX     = 8;
   localparam int OUT_COUNT   = (TUPLE_LEN < OUT_MAX) ? TUPLE_LEN : OUT_MAX;
   localparam int LAST_INDEX  = TUPLE_LEN - 1;
   localparam int IDX_W       = (TUPLE_LEN > 1) ? $clog2(TUPLE_LEN) : 1;
   localparam int CSR_W       = 16;
   localparam int COUNT_W     = 16;
   localparam int POS_W       = 3;
   localparam int OUT_VALUE_W = 16;
   localparam int RAD_W       = ((VALUE_BITS > CSR_W) ? VALUE_BITS : CSR_W) + 1;

   localparam logic [RAD_W-1:0] RADIUS_MAX = RAD_W'((64'd1 << VALUE_BITS) - 64'd1);

   typedef struct packed {
      logic                  clear;
      logic                  rotate;
      logic                  step_a;
      logic                  step_b;
      logic                  step_c;
      logic [IDX_W-1:0]      wp;
      logic [VALUE_BITS-1:0] last_val;
      logic [VALUE_BITS-1:0] new_radius;
   } cell_cmd_type;

endpackage

FILE: sv/wce_cell.sv
module wce_cell
   import wce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [IDX_W-1:0]      cell_index,
   input  logic [VALUE_BITS-1:0] value_right_in,
   input  logic                  nz_right_in,
   input  logic                  pivot_left_in,
   output logic [VALUE_BITS-1:0] value_out,
   output logic                  nz_left_out,
   output logic                  pivot_out
);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  is_last;
   logic                  nonzero;
   logic                  is_wp;
   logic                  after_wp;

   assign is_last     = (cell_index == IDX_W'(LAST_INDEX));
   assign nonzero     = (value_ff != '0);
   assign pivot_out   = nonzero && !is_last && !nz_right_in;
   assign nz_left_out = nz_right_in || (nonzero && !is_last);
   assign value_out   = value_ff;
   assign is_wp       = (cmd.wp == cell_index);
   assign after_wp    = (({1'b0, cmd.wp} + (IDX_W+1)'(1)) == {1'b0, cell_index});

   always_comb begin
      value_in = value_ff;
      if (cmd.rotate) begin
         value_in = value_right_in;
      end else if (cmd.step_a) begin
         if (is_wp) begin
            value_in = value_ff - VALUE_BITS'(1);
         end else if (after_wp) begin
            value_in = value_ff + VALUE_BITS'(1);
         end
      end else if (cmd.step_b) begin
         if (pivot_out) begin
            value_in = value_ff - VALUE_BITS'(1);
         end else if (pivot_left_in) begin
            value_in = cmd.last_val + VALUE_BITS'(1);
         end else if (is_last) begin
            value_in = '0;
         end
      end else if (cmd.step_c) begin
         if (cell_index == '0) begin
            value_in = cmd.new_radius;
         end else if (is_last) begin
            value_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

FILE: sv/weak_composition_enumerator.sv
// Walks through all tuples of non-negative integers of fixed length whose sum is a radius,
// radius after radius, starting at the programmed start radius.
// Input channel (req_): each item carries advance_count, the number of enumeration steps
// to take. The block then returns the current tuple as one item per element on the
// result channel (rsp_), element 0 first, with rsp_last_element set on the final one and
// rsp_exhausted set once the largest radius has been passed.
// Enumeration steps are carried out in the row of element cells, and the first element
// is offered once all steps are done, or in the next cycle for a zero count. Once
// exhausted, the remaining steps are skipped. The block works on one item at a time:
// req_ready is high only while no item is in progress.
// Emission rotates the cell row by one place per element taken; while rsp_ready is low
// the row and the pending element simply hold.
// Reset, or a write on the csr_ port, clears all elements and restarts the enumeration
// at the written radius (zero after reset). Write csr_ only while the block is idle.
module weak_composition_enumerator
   import wce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COUNT_W-1:0]     req_advance_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_W-1:0]       rsp_position,
   output logic [OUT_VALUE_W-1:0] rsp_element_value,
   output logic                   rsp_last_element,
   output logic                   rsp_exhausted,
   input  logic                   csr_write_enable,
   input  logic [CSR_W-1:0]       csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   wp_ff, wp_in;
   logic [IDX_W-1:0]   rot_ff, rot_in;
   logic [RAD_W-1:0]   radius_ff, radius_in;
   logic               done_ff, done_in;

   cell_cmd_type          cmd;
   logic [VALUE_BITS-1:0] cell_value [TUPLE_LEN];
   logic                  nz_chain [TUPLE_LEN+1];
   logic                  pivot [TUPLE_LEN];

   logic             stepping;
   logic             cur_nz;
   logic             case_a;
   logic             case_b;
   logic             case_c;
   logic             at_max;
   logic             emit_adv;
   logic [IDX_W-1:0] pivot_wp;

   assign nz_chain[TUPLE_LEN] = 1'b0;

   for (genvar i = 0; i < TUPLE_LEN; i++) begin : g_cell
      wce_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .cell_index     (IDX_W'(i)),
         .value_right_in (cell_value[(i + 1) % TUPLE_LEN]),
         .nz_right_in    (nz_chain[i + 1]),
         .pivot_left_in  ((i == 0) ? 1'b0 : pivot[(i == 0) ? 0 : i - 1]),
         .value_out      (cell_value[i]),
         .nz_left_out    (nz_chain[i]),
         .pivot_out      (pivot[i])
      );
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_EMIT)
                              && ({1'b0, rot_ff} < (IDX_W+1)'(OUT_COUNT));
   assign rsp_position      = POS_W'(rot_ff);
   assign rsp_element_value = OUT_VALUE_W'(cell_value[0]);
   assign rsp_last_element  = (rot_ff == IDX_W'(OUT_COUNT - 1));
   assign rsp_exhausted     = done_ff;

   assign stepping = (state_ff == ST_STEP) && !done_ff;
   assign cur_nz   = (cell_value[wp_ff] != '0);
   assign case_a   = (wp_ff != IDX_W'(LAST_INDEX)) && cur_nz;
   assign case_b   = !case_a && nz_chain[0];
   assign case_c   = !case_a && !nz_chain[0];
   assign at_max   = ($signed(radius_ff) >= $signed(RADIUS_MAX));
   assign emit_adv = (state_ff == ST_EMIT) && (!rsp_valid || rsp_ready);

   always_comb begin
      pivot_wp = '0;
      for (int i = 0; i < TUPLE_LEN - 1; i++) begin
         if (pivot[i]) begin
            pivot_wp = pivot_wp | IDX_W'(i + 1);
         end
      end
   end

   always_comb begin
      cmd.clear      = csr_write_enable;
      cmd.rotate     = emit_adv;
      cmd.step_a     = stepping && case_a;
      cmd.step_b     = stepping && case_b;
      cmd.step_c     = stepping && case_c && !at_max;
      cmd.wp         = wp_ff;
      cmd.last_val   = cell_value[LAST_INDEX];
      cmd.new_radius = VALUE_BITS'(radius_ff + RAD_W'(1));
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      wp_in     = wp_ff;
      rot_in    = rot_ff;
      radius_in = radius_ff;
      done_in   = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               count_in = req_advance_count;
               state_in = (req_advance_count == '0) ? ST_EMIT : ST_STEP;
            end
         end
         ST_STEP: begin
            if (!done_ff) begin
               if (case_a) begin
                  wp_in = wp_ff + IDX_W'(1);
               end else if (case_b) begin
                  wp_in = pivot_wp;
               end else if (at_max) begin
                  done_in = 1'b1;
               end else begin
                  wp_in     = '0;
                  radius_in = radius_ff + RAD_W'(1);
               end
            end
            count_in = count_ff - COUNT_W'(1);
            if (done_ff || (count_ff == COUNT_W'(1))) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_adv) begin
               if (rot_ff == IDX_W'(LAST_INDEX)) begin
                  rot_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  rot_in = rot_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         wp_in     = IDX_W'(LAST_INDEX);
         radius_in = RAD_W'(csr_write_data) - RAD_W'(1);
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         wp_ff     <= IDX_W'(LAST_INDEX);
         rot_ff    <= '0;
         radius_ff <= '1;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         wp_ff     <= wp_in;
         rot_ff    <= rot_in;
         radius_ff <= radius_in;
         done_ff   <= done_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Input accepted while an item is being emitted.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (count_ff != '0))
      else $error("Stepping with no steps left.");

   assert property (@(posedge clock) disable iff (reset)
      $fell(done_ff) |-> ($past(csr_write_enable) || $past(reset)))
      else $error("Exhaustion cleared without reinitialization.");

endmodule

FILE: dv/weak_composition_checker.sv
module weak_composition_checker
   import wce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [COUNT_W-1:0]     req_advance_count,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [POS_W-1:0]       rsp_position,
   input  logic [OUT_VALUE_W-1:0] rsp_element_value,
   input  logic                   rsp_last_element,
   input  logic                   rsp_exhausted,
   input  logic                   csr_write_enable,
   input  logic [CSR_W-1:0]       csr_write_data,
   output int                     mismatch_count,
   output int                     pending_results
);

   typedef struct packed {
      logic [POS_W-1:0]       position;
      logic [OUT_VALUE_W-1:0] element_value;
      logic                   last_element;
      logic                   exhausted;
   } element_item_type;

   localparam longint RADIUS_TOP = (longint'(1) << VALUE_BITS) - 1;

   logic [VALUE_BITS-1:0] tuple_elems [TUPLE_LEN];
   int                    work_pos;
   longint                cur_radius;
   logic                  enum_held;
   element_item_type      expected_elements [$];
   int                    mismatches = 0;

   function automatic void restart_enumeration(input logic [CSR_W-1:0] first_radius);
      for (int i = 0; i < TUPLE_LEN; i++) begin
         tuple_elems[i] = '0;
      end
      work_pos   = LAST_INDEX;
      cur_radius = first_radius;
      cur_radius = cur_radius - 1;
      enum_held  = 1'b0;
   endfunction

   function automatic void advance_tuple();
      int j;
      if (work_pos != LAST_INDEX && tuple_elems[work_pos] != 0) begin
         tuple_elems[work_pos] = tuple_elems[work_pos] - 1'b1;
         work_pos++;
         tuple_elems[work_pos] = tuple_elems[work_pos] + 1'b1;
         return;
      end
      j = LAST_INDEX - 1;
      while (j >= 0 && tuple_elems[j] == 0) begin
         j--;
      end
      if (j < 0) begin
         if (cur_radius >= RADIUS_TOP) begin
            enum_held = 1'b1;
            return;
         end
         cur_radius++;
         work_pos       = 0;
         tuple_elems[0] = cur_radius[VALUE_BITS-1:0];
      end else begin
         tuple_elems[j]        = tuple_elems[j] - 1'b1;
         work_pos              = j + 1;
         tuple_elems[work_pos] = tuple_elems[LAST_INDEX] + 1'b1;
      end
      if (work_pos != LAST_INDEX) begin
         tuple_elems[LAST_INDEX] = '0;
      end
   endfunction

   function automatic void queue_tuple();
      element_item_type item;
      for (int k = 0; k < OUT_COUNT; k++) begin
         item.position      = POS_W'(k);
         item.element_value = OUT_VALUE_W'(tuple_elems[k]);
         item.last_element  = (k == OUT_COUNT - 1);
         item.exhausted     = enum_held;
         expected_elements.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      element_item_type seen;
      element_item_type want;
      if (reset) begin
         restart_enumeration('0);
         expected_elements.delete();
      end else begin
         if (csr_write_enable) begin
            restart_enumeration(csr_write_data);
         end
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_position, rsp_element_value, rsp_last_element, rsp_exhausted};
            if (expected_elements.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result item: position %0d value %0d last %0b exhausted %0b",
                     seen.position, seen.element_value, seen.last_element, seen.exhausted);
               end
            end else begin
               want = expected_elements.pop_front();
               if (seen.position !== want.position ||
                   seen.element_value !== want.element_value ||
                   seen.last_element !== want.last_element ||
                   seen.exhausted !== want.exhausted) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"element mismatch: expected position %0d value %0d last %0b ",
                        "exhausted %0b, got position %0d value %0d last %0b exhausted %0b"},
                        want.position, want.element_value, want.last_element, want.exhausted,
                        seen.position, seen.element_value, seen.last_element, seen.exhausted);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            for (int n = 0; n < req_advance_count && !enum_held; n++) begin
               advance_tuple();
            end
            queue_tuple();
         end
      end
      mismatch_count  <= mismatches;
      pending_results <= expected_elements.size();
   end

endmodule

FILE: dv/weak_composition_enumerator_tb.sv
module weak_composition_enumerator_tb;
   import wce_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PHASE_ITEMS = 78;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [COUNT_W-1:0]     req_advance_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [POS_W-1:0]       rsp_position;
   logic [OUT_VALUE_W-1:0] rsp_element_value;
   logic                   rsp_last_element;
   logic                   rsp_exhausted;
   logic                   csr_write_enable  = 1'b0;
   logic [CSR_W-1:0]       csr_write_data    = '0;

   int mismatch_count;
   int pending_results;
   int cycle_count = 0;
   int burst_left  = 0;
   int big_left    = 3;
   int ready_hold  = 0;
   int ready_mode  = 0;

   weak_composition_enumerator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_advance_count(req_advance_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_element_value(rsp_element_value),
      .rsp_last_element (rsp_last_element),
      .rsp_exhausted    (rsp_exhausted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   weak_composition_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_advance_count(req_advance_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_element_value(rsp_element_value),
      .rsp_last_element (rsp_last_element),
      .rsp_exhausted    (rsp_exhausted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("weak_composition_enumerator: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_hold <= $urandom_range(8, 64);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 7) != 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   task automatic send_steps(input logic [COUNT_W-1:0] step_count);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 10);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_advance_count <= step_count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_start_radius(input logic [CSR_W-1:0] radius_value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= radius_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [COUNT_W-1:0] pick_step_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         return '0;
      end
      if (roll < 55) begin
         return COUNT_W'($urandom_range(1, 8));
      end
      if (roll < 82) begin
         return COUNT_W'($urandom_range(9, 64));
      end
      if (roll < 97) begin
         return COUNT_W'($urandom_range(65, 1023));
      end
      if (big_left > 0) begin
         big_left--;
         return COUNT_W'($urandom_range(1024, 65535));
      end
      return COUNT_W'($urandom_range(1, 40));
   endfunction

   task automatic run_random_phase(input logic [CSR_W-1:0] radius_value);
      write_start_radius(radius_value);
      repeat (PHASE_ITEMS) send_steps(pick_step_count());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the tuple is all zeros, then radius zero leads straight to radius one.
      send_steps(16'd0);
      send_steps(16'd1);
      send_steps(16'd1);
      send_steps(16'd1);
      send_steps(16'd2);
      send_steps(16'd5);
      send_steps(16'd7);
      send_steps(16'd8);
      send_steps(16'd9);

      write_start_radius(16'd0);
      send_steps(16'd1);
      send_steps(16'hFFFF);

      write_start_radius(16'hFFFF);
      send_steps(16'd1);
      send_steps(16'd0);
      send_steps(16'd1);
      send_steps(16'd3);
      send_steps(16'hFFFF);

      write_start_radius(16'd1);
      send_steps(16'd1);
      send_steps(16'd2);
      send_steps(16'd30);

      run_random_phase(CSR_W'($urandom_range(0, 65535)));
      run_random_phase(16'hAAAA);
      run_random_phase(16'h5555);
      run_random_phase(16'd0);
      run_random_phase(16'hFFFF);
      settle();

      if (mismatch_count == 0) begin
         $display("weak_composition_enumerator: match");
      end else begin
         $display("weak_composition_enumerator: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/wce_pkg.sv
sv/wce_cell.sv
sv/weak_composition_enumerator.sv
dv/weak_composition_checker.sv
dv/weak_composition_enumerator_tb.sv
